@@ design/c3mc_pkg.sv @@
// Shared beat types and codes for the multichannel 3x3 convolution unit.
package c3mc_pkg;

   localparam int VALUE_W = 16;
   localparam int FRAC_W  = 10;
   localparam int TAG_W   = 6;
   localparam int FID_W   = 3;

   localparam logic [1:0] MODE_WEIGHT = 2'd0;
   localparam logic [1:0] MODE_BIAS   = 2'd1;
   localparam logic [1:0] MODE_PIXEL  = 2'd2;

   typedef struct packed {
      logic [1:0]                mode;
      logic [7:0]                load_index;
      logic signed [VALUE_W-1:0] load_value;
      logic signed [VALUE_W-1:0] chan_a;
      logic signed [VALUE_W-1:0] chan_b;
      logic signed [VALUE_W-1:0] chan_c;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]          out_row;
      logic [TAG_W-1:0]          out_col;
      logic [FID_W-1:0]          filter_id;
      logic signed [VALUE_W-1:0] result_value;
      logic                      last;
   } rsp_type;

   // Position and filter that travel alongside one result through the adder tree.
   typedef struct packed {
      logic [TAG_W-1:0] row;
      logic [TAG_W-1:0] col;
      logic [FID_W-1:0] filter;
      logic             last;
   } tag_type;

endpackage

@@ design/c3mc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module c3mc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/c3mc_lane.sv @@
// One multiplier lane: the weights of one window tap for every filter, and its product.
module c3mc_lane #(
   parameter int LANE         = 0,
   parameter int FILTER_COUNT = 8
) (
   input  logic                                               clock,
   input  logic                                               en,
   input  logic                                               wr_en,
   input  logic [7:0]                                         wr_index,
   input  logic signed [c3mc_pkg::VALUE_W-1:0]                wr_value,
   input  logic [(FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1)-1:0] rd_filter,
   input  logic signed [c3mc_pkg::VALUE_W-1:0]                pixel,
   output logic [c3mc_pkg::VALUE_W-1:0]                       prod
);
   import c3mc_pkg::*;

   localparam int FILT_W = FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1;
   localparam int LO     = LANE * FILTER_COUNT;

   logic                     hit;
   logic [FILT_W-1:0]        wr_addr;
   logic [VALUE_W-1:0]       weight;
   logic signed [2*VALUE_W-1:0] full;
   logic [VALUE_W-1:0]       prod_ff;

   assign hit     = wr_en && (int'(wr_index) >= LO) && (int'(wr_index) < LO + FILTER_COUNT);
   assign wr_addr = FILT_W'(int'(wr_index) - LO);

   c3mc_ram #(.WIDTH(VALUE_W), .DEPTH(FILTER_COUNT)) u_weights (
      .clock   (clock),
      .wr_en   (hit),
      .wr_addr (wr_addr),
      .wr_data (wr_value),
      .rd_addr (rd_filter),
      .rd_data (weight)
   );

   // The floor shift by the fraction width keeps only bits that survive the 16-bit wrap.
   assign full = pixel * $signed(weight);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= full[FRAC_W +: VALUE_W];
      end
   end

   assign prod = prod_ff;
endmodule

@@ design/c3mc_merge.sv @@
// Registered adder tree that merges the lane products and the bias into one result beat.
module c3mc_merge #(
   parameter int ROW_COUNT = 3,
   parameter int ROW_LANES = 9
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           en,
   input  logic                                           i_valid,
   input  c3mc_pkg::tag_type                              i_tag,
   input  logic [c3mc_pkg::VALUE_W-1:0]                   i_bias,
   input  logic [ROW_COUNT*ROW_LANES-1:0][c3mc_pkg::VALUE_W-1:0] lane_prod,
   output logic                                           rsp_valid,
   output c3mc_pkg::rsp_type                              rsp_data
);
   import c3mc_pkg::*;

   logic               m_valid_ff, s_valid_ff, o_valid_ff;
   tag_type            m_tag_ff, s_tag_ff;
   logic [VALUE_W-1:0] m_bias_ff, s_bias_ff;
   logic [VALUE_W-1:0] s_row_ff [ROW_COUNT];
   logic [VALUE_W-1:0] s_row_in [ROW_COUNT];
   logic [VALUE_W-1:0] total;
   rsp_type            o_data_ff;

   always_comb begin
      for (int r = 0; r < ROW_COUNT; r++) begin
         s_row_in[r] = '0;
         for (int l = 0; l < ROW_LANES; l++) begin
            s_row_in[r] = s_row_in[r] + lane_prod[r*ROW_LANES + l];
         end
      end
      total = s_bias_ff;
      for (int r = 0; r < ROW_COUNT; r++) begin
         total = total + s_row_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= i_valid;
         s_valid_ff <= m_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_tag_ff  <= i_tag;
         m_bias_ff <= i_bias;
         s_tag_ff  <= m_tag_ff;
         s_bias_ff <= m_bias_ff;
         s_row_ff  <= s_row_in;
         o_data_ff.out_row      <= s_tag_ff.row;
         o_data_ff.out_col      <= s_tag_ff.col;
         o_data_ff.filter_id    <= s_tag_ff.filter;
         o_data_ff.result_value <= total;
         o_data_ff.last         <= s_tag_ff.last;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;
endmodule

@@ design/conv2d_3x3_multichannel_unit.sv @@
// Top level of the streaming multichannel 3x3 convolution unit.
// A pixel beat that completes a window produces FILTER_COUNT result beats, one per cycle
// unless the result path stalls, paced by the filter counter that steps the lane weight
// stores, one filter per cycle. A pixel that completes no window does not wait on that
// counter, and later pixels may enter the pixel stage while a window is issued. Weight and
// bias loads are held off while a window is still being issued to the lanes, so they always
// follow earlier pixels in order. The line store needs no clearing pass: its contents only
// reach results once the current frame has written them.
module conv2d_3x3_multichannel_unit #(
   parameter int IMAGE_SIDE    = 64,
   parameter int KERNEL_SIDE   = 3,
   parameter int CHANNEL_COUNT = 3,
   parameter int FILTER_COUNT  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  c3mc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output c3mc_pkg::rsp_type rsp_data
);
   import c3mc_pkg::*;

   localparam int COL_W     = $clog2(IMAGE_SIDE);
   localparam int FILT_W    = FILTER_COUNT > 1 ? $clog2(FILTER_COUNT) : 1;
   localparam int PIX_W     = CHANNEL_COUNT * VALUE_W;
   localparam int ROW_LANES = KERNEL_SIDE * CHANNEL_COUNT;
   localparam int LANES     = KERNEL_SIDE * ROW_LANES;
   localparam int LINE_ROWS = KERNEL_SIDE > 1 ? KERNEL_SIDE - 1 : 1;

   logic req_fire, pix_fire;
   logic [PIX_W-1:0] pix_in;

   // Raster position of the next pixel.
   logic [COL_W-1:0] pixel_row_ff, pixel_col_ff, pixel_row_in, pixel_col_in;

   // Pixel stage: the accepted pixel waits here for its line store read.
   logic             p_valid_ff, p_complete_ff;
   logic [PIX_W-1:0] p_pix_ff;
   logic [COL_W-1:0] p_col_ff, p_orow_ff, p_ocol_ff;
   logic             p_go, p_fire;

   logic [COL_W-1:0] line_addr;
   logic [PIX_W-1:0] line_rd [LINE_ROWS];
   logic [PIX_W-1:0] column [KERNEL_SIDE];
   logic [PIX_W-1:0] win_ff [KERNEL_SIDE][KERNEL_SIDE];
   logic [PIX_W-1:0] win_in [KERNEL_SIDE][KERNEL_SIDE];

   // Issue stage: a frozen copy of the window is fed to the lanes, one filter per cycle unless stalled.
   logic                            busy_ff, busy_in;
   logic [FILT_W-1:0]               filt_ff, filt_in;
   logic [LANES-1:0][VALUE_W-1:0]   snap_ff, snap_in;
   logic [COL_W-1:0]                i_row_ff, i_col_ff;
   logic                            last_filt, issue_free, start, adv;
   logic [LANES-1:0][VALUE_W-1:0]   lane_prod;
   logic [VALUE_W-1:0]              bias_rd;
   tag_type                         i_tag;

   // Loads wait until no window is in flight towards the lanes; pixels wait on the pixel stage.
   always_comb begin
      if (req_data.mode == MODE_PIXEL) begin
         req_stall = p_valid_ff && !p_go;
      end else if (req_data.mode == MODE_WEIGHT || req_data.mode == MODE_BIAS) begin
         req_stall = p_valid_ff || busy_ff;
      end else begin
         req_stall = 1'b0;
      end
   end

   assign req_fire = req_valid && !req_stall;
   assign pix_fire = req_fire && (req_data.mode == MODE_PIXEL);

   always_comb begin
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
         if (ch == 0) begin
            pix_in[ch*VALUE_W +: VALUE_W] = req_data.chan_a;
         end else if (ch == 1) begin
            pix_in[ch*VALUE_W +: VALUE_W] = req_data.chan_b;
         end else if (ch == 2) begin
            pix_in[ch*VALUE_W +: VALUE_W] = req_data.chan_c;
         end else begin
            pix_in[ch*VALUE_W +: VALUE_W] = '0;
         end
      end
   end

   always_comb begin
      pixel_row_in = pixel_row_ff;
      pixel_col_in = pixel_col_ff;
      if (pix_fire) begin
         if (pixel_col_ff == COL_W'(IMAGE_SIDE - 1)) begin
            pixel_col_in = '0;
            pixel_row_in = (pixel_row_ff == COL_W'(IMAGE_SIDE - 1)) ? '0 : pixel_row_ff + 1'b1;
         end else begin
            pixel_col_in = pixel_col_ff + 1'b1;
         end
      end
   end

   assign adv        = !rsp_valid || !rsp_stall;
   assign last_filt  = filt_ff == FILT_W'(FILTER_COUNT - 1);
   assign issue_free = !busy_ff || (last_filt && adv);
   assign p_go       = p_valid_ff && (!p_complete_ff || issue_free);
   assign p_fire     = p_go;
   assign start      = p_fire && p_complete_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_row_ff <= '0;
         pixel_col_ff <= '0;
         p_valid_ff   <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         pixel_row_ff <= pixel_row_in;
         pixel_col_ff <= pixel_col_in;
         if (pix_fire) begin
            p_valid_ff <= 1'b1;
         end else if (p_fire) begin
            p_valid_ff <= 1'b0;
         end
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         p_pix_ff      <= pix_in;
         p_col_ff      <= pixel_col_ff;
         p_complete_ff <= (int'(pixel_row_ff) >= KERNEL_SIDE - 1)
                          && (int'(pixel_col_ff) >= KERNEL_SIDE - 1);
         p_orow_ff     <= COL_W'(int'(pixel_row_ff) - (KERNEL_SIDE - 1));
         p_ocol_ff     <= COL_W'(int'(pixel_col_ff) - (KERNEL_SIDE - 1));
      end
   end

   // While a pixel is held, its own column is read again so the data stays current.
   assign line_addr = (p_valid_ff && !p_go) ? p_col_ff : pixel_col_ff;

   generate
      if (KERNEL_SIDE > 1) begin : g_lines
         for (genvar r = 0; r < LINE_ROWS; r++) begin : g_row
            logic [PIX_W-1:0] wr_data;
            if (r == LINE_ROWS - 1) begin : g_top
               assign wr_data = p_pix_ff;
            end else begin : g_mid
               assign wr_data = line_rd[r + 1];
            end
            c3mc_ram #(.WIDTH(PIX_W), .DEPTH(IMAGE_SIDE)) u_line (
               .clock   (clock),
               .wr_en   (p_fire),
               .wr_addr (p_col_ff),
               .wr_data (wr_data),
               .rd_addr (line_addr),
               .rd_data (line_rd[r])
            );
         end
      end else begin : g_nolines
         assign line_rd[0] = '0;
      end
   endgenerate

   always_comb begin
      for (int ki = 0; ki < KERNEL_SIDE; ki++) begin
         column[ki] = (ki < KERNEL_SIDE - 1) ? line_rd[ki] : p_pix_ff;
      end
      for (int ki = 0; ki < KERNEL_SIDE; ki++) begin
         for (int kj = 0; kj < KERNEL_SIDE; kj++) begin
            if (kj < KERNEL_SIDE - 1) begin
               win_in[ki][kj] = win_ff[ki][kj + 1];
            end else begin
               win_in[ki][kj] = column[ki];
            end
         end
      end
      for (int ki = 0; ki < KERNEL_SIDE; ki++) begin
         for (int kj = 0; kj < KERNEL_SIDE; kj++) begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
               snap_in[(ki*KERNEL_SIDE + kj)*CHANNEL_COUNT + ch] =
                  win_in[ki][kj][ch*VALUE_W +: VALUE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_fire) begin
         win_ff <= win_in;
      end
      if (start) begin
         snap_ff  <= snap_in;
         i_row_ff <= p_orow_ff;
         i_col_ff <= p_ocol_ff;
      end
      filt_ff <= filt_in;
   end

   // The weight stores are addressed with the next filter so their data lines up with filt_ff.
   always_comb begin
      busy_in = busy_ff;
      filt_in = filt_ff;
      if (start) begin
         busy_in = 1'b1;
         filt_in = '0;
      end else if (busy_ff && adv) begin
         if (last_filt) begin
            busy_in = 1'b0;
         end else begin
            filt_in = filt_ff + 1'b1;
         end
      end
   end

   generate
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         c3mc_lane #(.LANE(l), .FILTER_COUNT(FILTER_COUNT)) u_lane (
            .clock     (clock),
            .en        (adv),
            .wr_en     (req_fire && (req_data.mode == MODE_WEIGHT)),
            .wr_index  (req_data.load_index),
            .wr_value  (req_data.load_value),
            .rd_filter (filt_in),
            .pixel     (snap_ff[l]),
            .prod      (lane_prod[l])
         );
      end
   endgenerate

   c3mc_ram #(.WIDTH(VALUE_W), .DEPTH(FILTER_COUNT)) u_bias (
      .clock   (clock),
      .wr_en   (req_fire && (req_data.mode == MODE_BIAS)
                && (int'(req_data.load_index) < FILTER_COUNT)),
      .wr_addr (req_data.load_index[FILT_W-1:0]),
      .wr_data (req_data.load_value),
      .rd_addr (filt_in),
      .rd_data (bias_rd)
   );

   assign i_tag.row    = TAG_W'(i_row_ff);
   assign i_tag.col    = TAG_W'(i_col_ff);
   assign i_tag.filter = FID_W'(filt_ff);
   assign i_tag.last   = last_filt;

   c3mc_merge #(.ROW_COUNT(KERNEL_SIDE), .ROW_LANES(ROW_LANES)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .i_valid   (busy_ff),
      .i_tag     (i_tag),
      .i_bias    (bias_rd),
      .lane_prod (lane_prod),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A new window is only frozen once the previous one has handed its final filter on.
   assert property (@(posedge clock) disable iff (reset)
      start |-> (!busy_ff || (last_filt && adv)))
      else $error("window issued over a busy filter sequence");

   // A stalled result path freezes the filter sequence.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !adv) |=> $stable(filt_ff))
      else $error("filter counter moved during a stall");

   // The final beat of a pixel carries the highest filter number.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.filter_id == FID_W'(FILTER_COUNT - 1)))
      else $error("last beat on the wrong filter");

   // An empty pixel stage always takes a pixel beat.
   assert property (@(posedge clock) disable iff (reset)
      (!p_valid_ff && req_data.mode == MODE_PIXEL) |-> !req_stall)
      else $error("pixel beat stalled with the pixel stage empty");

endmodule

@@ tb/tb_conv2d_3x3_multichannel_unit.sv @@
// Self-checking testbench for the multichannel 3x3 convolution unit.
`timescale 1ns / 100ps

module tb_conv2d_3x3_multichannel_unit;
   import c3mc_pkg::*;

   localparam int SIDE    = 64;
   localparam int FILTERS = 8;
   localparam int NWEIGHT = 216;

   // Scoreboard: holds a private copy of the block's stores and computes the
   // results that each pixel beat should produce.
   class conv_scoreboard;
      logic signed [15:0] weights [NWEIGHT];
      logic signed [15:0] biases [FILTERS];
      logic signed [15:0] lines [2][SIDE][3];
      logic signed [15:0] window [3][3][3];
      int unsigned row_pos, col_pos;
      rsp_type pending_results [$];
      int mismatches;

      function new();
         foreach (weights[i]) weights[i] = '0;
         foreach (biases[i]) biases[i] = '0;
         foreach (lines[a, b, c]) lines[a][b][c] = '0;
         foreach (window[a, b, c]) window[a][b][c] = '0;
         row_pos = 0;
         col_pos = 0;
         mismatches = 0;
      endfunction

      function void note_request(req_type rq);
         logic signed [15:0] pix [3];
         logic signed [15:0] column [3][3];
         logic signed [15:0] acc;
         logic signed [31:0] prod;
         rsp_type rs;
         if (rq.mode == MODE_WEIGHT) begin
            if (rq.load_index < NWEIGHT) weights[rq.load_index] = rq.load_value;
            return;
         end
         if (rq.mode == MODE_BIAS) begin
            if (rq.load_index < FILTERS) biases[rq.load_index] = rq.load_value;
            return;
         end
         if (rq.mode != MODE_PIXEL) return;
         pix[0] = rq.chan_a;
         pix[1] = rq.chan_b;
         pix[2] = rq.chan_c;
         for (int ch = 0; ch < 3; ch++) begin
            column[0][ch] = lines[0][col_pos][ch];
            column[1][ch] = lines[1][col_pos][ch];
            column[2][ch] = pix[ch];
            lines[0][col_pos][ch] = lines[1][col_pos][ch];
            lines[1][col_pos][ch] = pix[ch];
         end
         for (int ki = 0; ki < 3; ki++)
            for (int ch = 0; ch < 3; ch++) begin
               window[ki][0][ch] = window[ki][1][ch];
               window[ki][1][ch] = window[ki][2][ch];
               window[ki][2][ch] = column[ki][ch];
            end
         if (row_pos >= 2 && col_pos >= 2) begin
            for (int f = 0; f < FILTERS; f++) begin
               acc = '0;
               for (int ki = 0; ki < 3; ki++)
                  for (int kj = 0; kj < 3; kj++)
                     for (int ch = 0; ch < 3; ch++) begin
                        prod = window[ki][kj][ch] * weights[((ki*3+kj)*3+ch)*8+f];
                        // Arithmetic shift floors towards minus infinity.
                        acc = acc + 16'(prod >>> 10);
                     end
               rs.out_row = 6'(row_pos - 2);
               rs.out_col = 6'(col_pos - 2);
               rs.filter_id = 3'(f);
               rs.result_value = acc + biases[f];
               rs.last = (f == FILTERS - 1);
               pending_results.push_back(rs);
            end
         end
         col_pos++;
         if (col_pos >= SIDE) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= SIDE) ? 0 : row_pos + 1;
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("result error: %s got %0d expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_result(rsp_type rs);
         rsp_type ex;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat, filter", rs.filter_id, -1);
            return;
         end
         ex = pending_results.pop_front();
         if (rs.out_row != ex.out_row) report_mismatch("out_row", rs.out_row, ex.out_row);
         if (rs.out_col != ex.out_col) report_mismatch("out_col", rs.out_col, ex.out_col);
         if (rs.filter_id != ex.filter_id)
            report_mismatch("filter_id", rs.filter_id, ex.filter_id);
         if (rs.result_value !== ex.result_value)
            report_mismatch("result_value", rs.result_value, ex.result_value);
         if (rs.last !== ex.last) report_mismatch("last", rs.last, ex.last);
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   conv_scoreboard board = new();

   // Idling percentages of the current phase, plus the long receiver hold-off.
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_active = 1'b0;
   event hold_request;

   always #1 clock = ~clock;

   conv2d_3x3_multichannel_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // The receiver: random stalls, or a solid stall while the hold-off runs.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) board.check_result(rsp_data);
      if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // The long hold-off, counted here in clock cycles once it is requested.
   initial begin
      @(hold_request);
      hold_active <= 1'b1;
      repeat (300) @(posedge clock);
      hold_active <= 1'b0;
   end

   // Offers one beat, idling first at random, and waits until it is taken.
   // The expectation is noted at the edge on which the beat is accepted.
   task send_beat(req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(rq);
   endtask

   task send_load(logic [1:0] mode, int idx, logic [15:0] val);
      req_type rq;
      rq = '0;
      rq.mode = mode;
      rq.load_index = 8'(idx);
      rq.load_value = val;
      rq.chan_a = 16'($urandom);
      send_beat(rq);
   endtask

   task send_pixel(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      req_type rq;
      rq = '0;
      rq.mode = MODE_PIXEL;
      rq.load_index = 8'($urandom);
      rq.load_value = 16'($urandom);
      rq.chan_a = a;
      rq.chan_b = b;
      rq.chan_c = c;
      send_beat(rq);
   endtask

   // Values biased towards the extremes so that every bit toggles and wraps occur.
   function logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(2047)) - 16'd1024;
         default: return 16'($urandom);
      endcase
   endfunction

   task load_all_stores();
      for (int i = 0; i < NWEIGHT; i++) send_load(MODE_WEIGHT, i, pick_value());
      for (int f = 0; f < FILTERS; f++) send_load(MODE_BIAS, f, pick_value());
   endtask

   // Drains: waits for every expected result, then lets the clock run on for slack.
   task drain();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      #2000000;
      $display("conv2d_3x3_multichannel_unit: mismatch");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every store written, including extremes; ignored beats.
      load_all_stores();
      send_load(MODE_WEIGHT, 216, 16'h1234);
      send_load(MODE_WEIGHT, 255, 16'h4321);
      send_load(MODE_BIAS, 8, 16'h7FFF);
      send_load(MODE_BIAS, 255, 16'h8000);
      send_load(2'd3, 0, 16'hFFFF);
      send_load(MODE_WEIGHT, 0, 16'h7FFF);
      send_load(MODE_WEIGHT, 215, 16'h8000);
      send_load(MODE_BIAS, 7, 16'h8000);
      send_load(MODE_BIAS, 0, 16'h7FFF);

      // Fill the first three rows with extreme and random pixels, covering the
      // incomplete windows and the first complete windows.
      for (int p = 0; p < 3 * SIDE + 10; p++) begin
         case (p % 4)
            0: send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
            1: send_pixel(16'h8000, 16'h8000, 16'h8000);
            default: send_pixel(pick_value(), pick_value(), pick_value());
         endcase
         if (p == 2 * SIDE + 5) begin
            // The receiver holds off while the sender keeps offering pixels.
            -> hold_request;
         end
      end

      // Random phases with different idling; stores reloaded while idle.
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         for (int i = 0; i < 16; i++)
            send_load($urandom_range(1) ? MODE_WEIGHT : MODE_BIAS,
                      $urandom_range(215), pick_value());
         for (int i = 0; i < 45; i++) begin
            if ($urandom_range(19) == 0)
               send_load(2'($urandom_range(3)), $urandom_range(255), pick_value());
            else
               send_pixel(pick_value(), pick_value(), pick_value());
         end
      end

      // Finish the frame quickly so the wrap to row zero is seen, then a few more.
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (board.row_pos != 0 || board.col_pos != 0)
         send_pixel(pick_value(), pick_value(), pick_value());
      for (int i = 0; i < 3 * SIDE + 4; i++)
         send_pixel(pick_value(), pick_value(), pick_value());
      drain();

      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("conv2d_3x3_multichannel_unit: match");
      end else begin
         $display("conv2d_3x3_multichannel_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/c3mc_pkg.sv
design/c3mc_ram.sv
design/c3mc_lane.sv
design/c3mc_merge.sv
design/conv2d_3x3_multichannel_unit.sv
tb/tb_conv2d_3x3_multichannel_unit.sv
